>>> rtl/rlt_pkg.sv
package rlt_pkg;

    localparam int LOG_ENTRIES_DEF = 32;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_REGION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_RESERVE = 1'b1;

    localparam logic [15:0] LOG_REGION_RST = 16'd33;
    localparam logic [5:0]  OP_RESERVE_RST = 6'd10;
    localparam logic [5:0]  OPEN_MAX       = 6'd63;

    typedef enum logic [1:0] {
        ACT_BEGIN  = 2'd0,
        ACT_END    = 2'd1,
        ACT_RECORD = 2'd2,
        ACT_DONE   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_GRANTED        = 4'd0,
        ST_WAIT           = 4'd1,
        ST_RELEASED       = 4'd2,
        ST_COMMIT_ENTRY   = 4'd3,
        ST_COMMIT_EMPTY   = 4'd4,
        ST_ABSORBED       = 4'd5,
        ST_APPENDED       = 4'd6,
        ST_FULL           = 4'd7,
        ST_OUTSIDE        = 4'd8,
        ST_END_IN_COMMIT  = 4'd9,
        ST_NONE_OPEN      = 4'd10,
        ST_CLEARED        = 4'd11,
        ST_NOT_COMMITTING = 4'd12
    } t_status;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_SCAN,
        FSM_EMIT,
        FSM_RESP
    } t_fsm;

    typedef struct packed {
        logic [15:0] log_region_blocks;
        logic [5:0]  op_reserve_blocks;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [31:0] logged_block;
        logic [4:0]  entry_index;
        logic [5:0]  entry_count;
        logic        last_entry;
        logic        wake_waiters;
    } t_result;

endpackage

>>> rtl/rlt_table_mem.sv
module rlt_table_mem #(
    parameter int DEPTH = rlt_pkg::LOG_ENTRIES_DEF,
    parameter int AW    = $clog2(rlt_pkg::LOG_ENTRIES_DEF)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

>>> rtl/rlt_ctrl.sv
module rlt_ctrl #(
    parameter int LOG_ENTRIES = rlt_pkg::LOG_ENTRIES_DEF,
    parameter int AW          = $clog2(LOG_ENTRIES),
    parameter int CW          = $clog2(LOG_ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rlt_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  logic [31:0]      i_block_number,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output rlt_pkg::t_result o_res,
    output logic             o_mem_wr_en,
    output logic [AW-1:0]    o_mem_wr_addr,
    output logic [31:0]      o_mem_wr_data,
    output logic [AW-1:0]    o_mem_rd_addr,
    input  logic [31:0]      i_mem_rd_data
);

    localparam int NW = CW + 13;

    rlt_pkg::t_fsm    r_state, n_state;
    rlt_pkg::t_action r_action;
    logic [31:0]      r_blk;
    logic [5:0]       r_open, n_open;
    logic             r_busy, n_busy;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    rlt_pkg::t_status r_res_status, n_res_status;
    logic [AW-1:0]    r_res_idx, n_res_idx;
    logic             r_res_wake, n_res_wake;
    logic             r_out_valid, n_out_valid;
    rlt_pkg::t_result r_out, n_out;

    logic          out_free;
    logic          load_out;
    logic [6:0]    open_p1;
    logic [12:0]   reserve_need;
    logic [NW-1:0] need;
    logic          table_full;
    logic          idx_is_last;
    logic [31:0]   idx_ext;
    logic [31:0]   res_idx_ext;
    logic [31:0]   count_ext;

    assign out_free     = !r_out_valid || i_res_ready;
    assign open_p1      = {1'b0, r_open} + 7'd1;
    assign reserve_need = 13'(open_p1) * 13'(i_cfg.op_reserve_blocks);
    assign need         = NW'(r_count) + NW'(reserve_need);
    assign table_full   = (32'(r_count) >= 32'(LOG_ENTRIES))
                       || (32'(r_count) + 32'd1 >= 32'(i_cfg.log_region_blocks));
    assign idx_is_last  = (CW'(r_idx) + CW'(1)) == r_count;
    assign idx_ext      = 32'(r_idx);
    assign res_idx_ext  = 32'(r_res_idx);
    assign count_ext    = 32'(r_count);

    assign o_in_ready    = (r_state == rlt_pkg::FSM_IDLE);
    assign o_res_valid   = r_out_valid;
    assign o_res         = r_out;
    assign o_mem_wr_data = r_blk;
    assign o_mem_wr_addr = r_count[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_open       = r_open;
        n_busy       = r_busy;
        n_count      = r_count;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_wake   = 1'b0;
        load_out     = 1'b0;
        n_out        = r_out;
        o_mem_wr_en  = 1'b0;
        o_mem_rd_addr = r_idx;

        unique case (r_state)
            rlt_pkg::FSM_IDLE: begin
                if (i_in_valid) begin
                    n_state = rlt_pkg::FSM_EXEC;
                end
            end
            rlt_pkg::FSM_EXEC: begin
                n_state   = rlt_pkg::FSM_RESP;
                n_res_idx = '0;
                unique case (r_action)
                    rlt_pkg::ACT_BEGIN: begin
                        if (r_busy || r_open >= rlt_pkg::OPEN_MAX
                                || need > NW'(LOG_ENTRIES)) begin
                            n_res_status = rlt_pkg::ST_WAIT;
                        end else begin
                            n_open       = r_open + 6'd1;
                            n_res_status = rlt_pkg::ST_GRANTED;
                        end
                    end
                    rlt_pkg::ACT_END: begin
                        if (r_busy) begin
                            n_res_status = rlt_pkg::ST_END_IN_COMMIT;
                        end else if (r_open == 6'd0) begin
                            n_res_status = rlt_pkg::ST_NONE_OPEN;
                        end else if (r_open != 6'd1) begin
                            n_open       = r_open - 6'd1;
                            n_res_status = rlt_pkg::ST_RELEASED;
                            n_res_wake   = 1'b1;
                        end else begin
                            n_open = 6'd0;
                            n_busy = 1'b1;
                            if (r_count == '0) begin
                                n_res_status = rlt_pkg::ST_COMMIT_EMPTY;
                            end else begin
                                // start the list walk at slot 0
                                n_idx         = '0;
                                o_mem_rd_addr = '0;
                                n_state       = rlt_pkg::FSM_EMIT;
                            end
                        end
                    end
                    rlt_pkg::ACT_RECORD: begin
                        if (table_full) begin
                            n_res_status = rlt_pkg::ST_FULL;
                        end else if (r_open == 6'd0) begin
                            n_res_status = rlt_pkg::ST_OUTSIDE;
                        end else if (r_count == '0) begin
                            o_mem_wr_en  = 1'b1;
                            n_count      = CW'(1);
                            n_res_status = rlt_pkg::ST_APPENDED;
                        end else begin
                            n_idx         = '0;
                            o_mem_rd_addr = '0;
                            n_state       = rlt_pkg::FSM_SCAN;
                        end
                    end
                    rlt_pkg::ACT_DONE: begin
                        if (!r_busy) begin
                            n_res_status = rlt_pkg::ST_NOT_COMMITTING;
                        end else begin
                            n_count      = '0;
                            n_busy       = 1'b0;
                            n_res_status = rlt_pkg::ST_CLEARED;
                            n_res_wake   = 1'b1;
                        end
                    end
                    default: begin
                        n_res_status = rlt_pkg::ST_NOT_COMMITTING;
                    end
                endcase
            end
            rlt_pkg::FSM_SCAN: begin
                // read data holds the word of slot r_idx
                if (i_mem_rd_data == r_blk) begin
                    n_res_status = rlt_pkg::ST_ABSORBED;
                    n_res_idx    = r_idx;
                    n_state      = rlt_pkg::FSM_RESP;
                end else if (idx_is_last) begin
                    o_mem_wr_en  = 1'b1;
                    n_count      = r_count + CW'(1);
                    n_res_status = rlt_pkg::ST_APPENDED;
                    n_res_idx    = r_count[AW-1:0];
                    n_state      = rlt_pkg::FSM_RESP;
                end else begin
                    n_idx         = r_idx + AW'(1);
                    o_mem_rd_addr = r_idx + AW'(1);
                end
            end
            rlt_pkg::FSM_EMIT: begin
                // re-read the same slot while the output stalls
                if (out_free) begin
                    load_out           = 1'b1;
                    n_out.status       = rlt_pkg::ST_COMMIT_ENTRY;
                    n_out.logged_block = i_mem_rd_data;
                    n_out.entry_index  = idx_ext[4:0];
                    n_out.entry_count  = count_ext[5:0];
                    n_out.last_entry   = idx_is_last;
                    n_out.wake_waiters = 1'b0;
                    if (idx_is_last) begin
                        n_state = rlt_pkg::FSM_IDLE;
                    end else begin
                        n_idx         = r_idx + AW'(1);
                        o_mem_rd_addr = r_idx + AW'(1);
                    end
                end
            end
            rlt_pkg::FSM_RESP: begin
                n_res_wake = r_res_wake;
                if (out_free) begin
                    load_out           = 1'b1;
                    n_out.status       = r_res_status;
                    n_out.logged_block = '0;
                    n_out.entry_index  = res_idx_ext[4:0];
                    n_out.entry_count  = count_ext[5:0];
                    n_out.last_entry   = 1'b1;
                    n_out.wake_waiters = r_res_wake;
                    n_state            = rlt_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = rlt_pkg::FSM_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlt_pkg::FSM_IDLE;
            r_open      <= '0;
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= rlt_pkg::t_action'(i_action);
            r_blk    <= i_block_number;
        end
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_wake   <= n_res_wake;
        r_out        <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(LOG_ENTRIES))
        else $error("table count beyond depth");

    a_commit_no_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_open == 6'd0))
        else $error("operations open during commit");

    a_emit_in_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlt_pkg::FSM_EMIT) |-> (r_busy && r_count != '0))
        else $error("list walk outside commit");

    a_write_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("table write without count advance");

endmodule

>>> rtl/redo_log_transaction_tracker_top.sv
// Group-commit redo log tracker.
// Input channel (i_in_valid/o_in_ready) takes one item: an action (begin, end,
// record block write, commit done) and a block number used by record.
// Output channel (o_out_valid/i_out_ready) returns result items; the last
// result of an item has o_last_entry set. Config channel (i_cfg_valid/
// o_cfg_ready, always ready) writes log_region_blocks (index 0) and
// op_reserve_blocks (index 1).
// One item is worked at a time. Begin, end without commit, commit done and
// rejected records pass through the execute and response states. A record
// scans the block table through the registered memory read port, one slot a
// cycle, until it matches or passes the last filled slot. The end that starts
// a commit emits one table entry per cycle while the receiver accepts.
// A result sits in an output register; while the receiver stalls the block
// holds it and does not advance. Reset empties the table, clears the open
// count and commit flag, and restores both config registers to defaults.
// The table memory needs no clearing pass: only filled slots are read.
module redo_log_transaction_tracker_top #(
    parameter int LOG_ENTRIES = rlt_pkg::LOG_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [31:0]                    i_block_number,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [3:0]                     o_status,
    output logic [31:0]                    o_logged_block,
    output logic [4:0]                     o_entry_index,
    output logic [5:0]                     o_entry_count,
    output logic                           o_last_entry,
    output logic                           o_wake_waiters,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rlt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    localparam int AW = $clog2(LOG_ENTRIES);
    localparam int CW = $clog2(LOG_ENTRIES + 1);

    rlt_pkg::t_cfg    r_cfg;
    rlt_pkg::t_result res;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [31:0]      mem_wr_data;
    logic [AW-1:0]    mem_rd_addr;
    logic [31:0]      mem_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log_region_blocks <= rlt_pkg::LOG_REGION_RST;
            r_cfg.op_reserve_blocks <= rlt_pkg::OP_RESERVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rlt_pkg::CFG_LOG_REGION: r_cfg.log_region_blocks <= i_cfg_data;
                rlt_pkg::CFG_OP_RESERVE: r_cfg.op_reserve_blocks <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    rlt_ctrl #(
        .LOG_ENTRIES (LOG_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .o_res_valid    (o_out_valid),
        .i_res_ready    (i_out_ready),
        .o_res          (res),
        .o_mem_wr_en    (mem_wr_en),
        .o_mem_wr_addr  (mem_wr_addr),
        .o_mem_wr_data  (mem_wr_data),
        .o_mem_rd_addr  (mem_rd_addr),
        .i_mem_rd_data  (mem_rd_data)
    );

    rlt_table_mem #(
        .DEPTH (LOG_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_status       = res.status;
    assign o_logged_block = res.logged_block;
    assign o_entry_index  = res.entry_index;
    assign o_entry_count  = res.entry_count;
    assign o_last_entry   = res.last_entry;
    assign o_wake_waiters = res.wake_waiters;

endmodule

>>> sim/redo_log_transaction_tracker_top_test.sv
module redo_log_transaction_tracker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rlt_pkg::*;

    localparam int LOG_ENTRIES = LOG_ENTRIES_DEF;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef enum {
        MODE_MIXED,
        MODE_SATURATE,
        MODE_DRAIN
    } t_mode;

    typedef struct {
        bit          region_write;
        t_action     act;
        logic [31:0] blk;
        bit          typed;
        t_result     want;
    } t_stim_row;

    typedef struct {
        logic [15:0] region;
        logic [15:0] reserve;
        t_mode       mode;
        int          items;
        bit          quiet;
    } t_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_action              i_action = ACT_BEGIN;
    logic [31:0]          i_block_number = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [3:0]           o_status;
    logic [31:0]          o_logged_block;
    logic [4:0]           o_entry_index;
    logic [5:0]           o_entry_count;
    logic                 o_last_entry;
    logic                 o_wake_waiters;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LOG_REGION;
    logic [15:0]          i_cfg_data = '0;

    // tracker state as the block should hold it
    logic [15:0] cfg_region = LOG_REGION_RST;
    logic [5:0]  cfg_reserve = OP_RESERVE_RST;
    logic [5:0]  open_ops = '0;
    bit          commit_on = 1'b0;
    logic [5:0]  tbl_count = '0;
    logic [31:0] blk_table [LOG_ENTRIES];

    t_result     pending_log_results[$];
    t_stim_row   stim_rows[$];
    t_phase      phase_plan[6];
    int          err_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_armed = 1'b0;
    int          hold_count = 0;
    t_action     next_act;
    logic [31:0] next_blk;

    redo_log_transaction_tracker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_logged_block (o_logged_block),
        .o_entry_index  (o_entry_index),
        .o_entry_count  (o_entry_count),
        .o_last_entry   (o_last_entry),
        .o_wake_waiters (o_wake_waiters),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    function automatic t_result known(input t_status st, input int idx, input int cnt,
                                      input bit wake);
        t_result r;
        r.status = st;
        r.logged_block = '0;
        r.entry_index = idx[4:0];
        r.entry_count = cnt[5:0];
        r.last_entry = 1'b1;
        r.wake_waiters = wake;
        return r;
    endfunction

    task automatic log_result(input bit keep, input t_status st, input logic [31:0] blk,
                              input int idx, input bit last, input bit wake);
        t_result r;
        r.status = st;
        r.logged_block = blk;
        r.entry_index = idx[4:0];
        r.entry_count = tbl_count;
        r.last_entry = last;
        r.wake_waiters = wake;
        if (keep) begin
            pending_log_results.push_back(r);
        end
    endtask

    // Apply one accepted item to the tracker state; queue its results when keep is set.
    task automatic track_log_item(input t_action act, input logic [31:0] blk, input bit keep);
        int  need;
        int  slot;
        bit  found;
        case (act)
            ACT_BEGIN: begin
                need = int'(tbl_count) + (int'(open_ops) + 1) * int'(cfg_reserve);
                if (commit_on || open_ops >= OPEN_MAX || need > LOG_ENTRIES) begin
                    log_result(keep, ST_WAIT, '0, 0, 1'b1, 1'b0);
                end else begin
                    open_ops++;
                    log_result(keep, ST_GRANTED, '0, 0, 1'b1, 1'b0);
                end
            end
            ACT_END: begin
                if (commit_on) begin
                    log_result(keep, ST_END_IN_COMMIT, '0, 0, 1'b1, 1'b0);
                end else if (open_ops == 0) begin
                    log_result(keep, ST_NONE_OPEN, '0, 0, 1'b1, 1'b0);
                end else begin
                    open_ops--;
                    if (open_ops != 0) begin
                        log_result(keep, ST_RELEASED, '0, 0, 1'b1, 1'b1);
                    end else begin
                        commit_on = 1'b1;
                        if (tbl_count == 0) begin
                            log_result(keep, ST_COMMIT_EMPTY, '0, 0, 1'b1, 1'b0);
                        end else begin
                            for (int i = 0; i < int'(tbl_count); i++) begin
                                log_result(keep, ST_COMMIT_ENTRY, blk_table[i], i,
                                           i + 1 == int'(tbl_count), 1'b0);
                            end
                        end
                    end
                end
            end
            ACT_RECORD: begin
                // full check wins over everything, even a block that would absorb
                if (int'(tbl_count) >= LOG_ENTRIES ||
                    int'(tbl_count) + 1 >= int'(cfg_region)) begin
                    log_result(keep, ST_FULL, '0, 0, 1'b1, 1'b0);
                end else if (open_ops == 0) begin
                    log_result(keep, ST_OUTSIDE, '0, 0, 1'b1, 1'b0);
                end else begin
                    found = 1'b0;
                    slot = 0;
                    for (int i = 0; i < int'(tbl_count) && !found; i++) begin
                        if (blk_table[i] == blk) begin
                            found = 1'b1;
                            slot = i;
                        end
                    end
                    if (found) begin
                        log_result(keep, ST_ABSORBED, '0, slot, 1'b1, 1'b0);
                    end else begin
                        slot = int'(tbl_count);
                        blk_table[slot] = blk;
                        tbl_count++;
                        log_result(keep, ST_APPENDED, '0, slot, 1'b1, 1'b0);
                    end
                end
            end
            default: begin
                if (!commit_on) begin
                    log_result(keep, ST_NOT_COMMITTING, '0, 0, 1'b1, 1'b0);
                end else begin
                    tbl_count = '0;
                    commit_on = 1'b0;
                    log_result(keep, ST_CLEARED, '0, 0, 1'b1, 1'b1);
                end
            end
        endcase
    endtask

    function automatic logic [31:0] pick_block();
        case ($urandom_range(0, 3))
            0: begin
                // reuse a logged block to hit absorption at any slot
                if (tbl_count != 0) begin
                    return blk_table[$urandom_range(0, int'(tbl_count) - 1)];
                end
                return $urandom;
            end
            1: return 32'($urandom_range(0, 15));
            2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    task automatic choose_item(input t_mode mode, output t_action act,
                               output logic [31:0] blk);
        int r;
        r = $urandom_range(0, 99);
        blk = pick_block();
        act = ACT_RECORD;
        if (mode == MODE_MIXED && r < 8) begin
            act = t_action'($urandom_range(0, 3));
        end else if (commit_on) begin
            act = (r < 90) ? ACT_DONE : t_action'($urandom_range(0, 2));
        end else begin
            case (mode)
                MODE_SATURATE: act = (r < 95) ? ACT_BEGIN : ACT_RECORD;
                MODE_DRAIN: begin
                    if (open_ops == 0) begin
                        act = ACT_BEGIN;
                    end else begin
                        act = (r < 85) ? ACT_END : ACT_RECORD;
                    end
                end
                default: begin
                    if (open_ops == 0 || r < 38) begin
                        act = ACT_BEGIN;
                    end else if (r < 75) begin
                        act = ACT_RECORD;
                    end else begin
                        act = ACT_END;
                    end
                end
            endcase
        end
    endtask

    task automatic send_item(input t_action act, input logic [31:0] blk, input bit typed,
                             input t_result want);
        while (idle_on && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_block_number <= blk;
        do @(posedge i_clk); while (!o_in_ready);
        track_log_item(act, blk, !typed);
        if (typed) begin
            pending_log_results.push_back(want);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LOG_REGION) begin
            cfg_region = data;
        end else begin
            cfg_reserve = data[5:0];
        end
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic settle_tracker();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_log_results.size() != 0);
    endtask

    task automatic add_row(input t_action act, input logic [31:0] blk, input bit typed,
                           input t_result want);
        stim_rows.push_back('{1'b0, act, blk, typed, want});
    endtask

    always @(posedge i_clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 16) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_log_results.size() == 0) begin
                note_error($sformatf("unexpected result: st %0d blk %h idx %0d cnt %0d",
                                     o_status, o_logged_block, o_entry_index, o_entry_count));
            end else begin
                want = pending_log_results.pop_front();
                if (o_status !== want.status || o_logged_block !== want.logged_block ||
                    o_entry_index !== want.entry_index ||
                    o_entry_count !== want.entry_count ||
                    o_last_entry !== want.last_entry ||
                    o_wake_waiters !== want.wake_waiters) begin
                    note_error($sformatf(
                        "mismatch exp %0d %h %0d %0d %b %b got %0d %h %0d %0d %b %b",
                        want.status, want.logged_block, want.entry_index,
                        want.entry_count, want.last_entry, want.wake_waiters,
                        o_status, o_logged_block, o_entry_index, o_entry_count,
                        o_last_entry, o_wake_waiters));
                end
            end
        end
    end

    initial begin
        add_row(ACT_DONE,   32'h0,         1'b1, known(ST_NOT_COMMITTING, 0, 0, 1'b0));
        add_row(ACT_END,    32'h0,         1'b1, known(ST_NONE_OPEN, 0, 0, 1'b0));
        add_row(ACT_RECORD, 32'h0,         1'b1, known(ST_OUTSIDE, 0, 0, 1'b0));
        add_row(ACT_BEGIN,  32'h0,         1'b1, known(ST_GRANTED, 0, 0, 1'b0));
        add_row(ACT_BEGIN,  32'h0,         1'b0, '0);
        add_row(ACT_BEGIN,  32'h0,         1'b0, '0);
        // three open operations use up the reservation
        add_row(ACT_BEGIN,  32'h0,         1'b1, known(ST_WAIT, 0, 0, 1'b0));
        add_row(ACT_RECORD, 32'h0,         1'b1, known(ST_APPENDED, 0, 1, 1'b0));
        add_row(ACT_RECORD, 32'hFFFF_FFFF, 1'b1, known(ST_APPENDED, 1, 2, 1'b0));
        add_row(ACT_RECORD, 32'h0,         1'b1, known(ST_ABSORBED, 0, 2, 1'b0));
        add_row(ACT_BEGIN,  32'h0,         1'b0, '0);
        add_row(ACT_END,    32'h0,         1'b0, '0);
        add_row(ACT_END,    32'h0,         1'b0, '0);
        add_row(ACT_END,    32'h0,         1'b0, '0);
        add_row(ACT_BEGIN,  32'h0,         1'b1, known(ST_WAIT, 0, 2, 1'b0));
        add_row(ACT_END,    32'h0,         1'b1, known(ST_END_IN_COMMIT, 0, 2, 1'b0));
        add_row(ACT_RECORD, 32'h8000_0001, 1'b1, known(ST_OUTSIDE, 0, 2, 1'b0));
        add_row(ACT_DONE,   32'h0,         1'b1, known(ST_CLEARED, 0, 0, 1'b1));
        add_row(ACT_BEGIN,  32'h0,         1'b0, '0);
        add_row(ACT_END,    32'h0,         1'b1, known(ST_COMMIT_EMPTY, 0, 0, 1'b0));
        add_row(ACT_DONE,   32'h0,         1'b0, '0);
        // region write row: the log region shrinks to two blocks
        stim_rows.push_back('{1'b1, ACT_BEGIN, 32'd2, 1'b0, '0});
        add_row(ACT_BEGIN,  32'h0,         1'b0, '0);
        add_row(ACT_RECORD, 32'h1234_5678, 1'b0, '0);
        add_row(ACT_RECORD, 32'h1234_5678, 1'b1, known(ST_FULL, 0, 1, 1'b0));

        phase_plan[0] = '{16'hFFFF, 16'd1,     MODE_MIXED,    16, 1'b0};
        phase_plan[1] = '{16'd5,    16'd3,     MODE_MIXED,    12, 1'b0};
        phase_plan[2] = '{16'd33,   16'd0,     MODE_SATURATE, 24, 1'b1};
        phase_plan[3] = '{16'd33,   16'd0,     MODE_DRAIN,    18, 1'b1};
        phase_plan[4] = '{16'd2,    16'hFFFF,  MODE_MIXED,     8, 1'b0};
        phase_plan[5] = '{16'd33,   16'd32,    MODE_MIXED,     8, 1'b0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].region_write) begin
                settle_tracker();
                cfg_write(CFG_LOG_REGION, stim_rows[r].blk[15:0]);
                i_cfg_valid <= 1'b0;
            end else begin
                send_item(stim_rows[r].act, stim_rows[r].blk, stim_rows[r].typed,
                          stim_rows[r].want);
            end
        end

        foreach (phase_plan[p]) begin
            settle_tracker();
            cfg_write(CFG_LOG_REGION, phase_plan[p].region);
            cfg_write(CFG_OP_RESERVE, phase_plan[p].reserve);
            i_cfg_valid <= 1'b0;
            idle_on <= !phase_plan[p].quiet;
            // stall the receiver for a long stretch while items keep coming
            if (p == 0) begin
                hold_armed <= 1'b1;
            end
            repeat (phase_plan[p].items) begin
                choose_item(phase_plan[p].mode, next_act, next_blk);
                send_item(next_act, next_blk, 1'b0, '0);
            end
        end

        settle_tracker();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
